// ----- sv/extended_step_compare_timer_defines.svh -----
// Assertion macros for the extended step compare timer
`ifndef EXTENDED_STEP_COMPARE_TIMER_DEFINES_SVH
`define EXTENDED_STEP_COMPARE_TIMER_DEFINES_SVH

// same-cycle implication, reset masked
`define ESCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define ESCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/esct_pkg.sv -----
// Types, constants and compare placement function for the step compare timer
`timescale 1ns / 1ps
`default_nettype none

package esct_pkg;

	typedef enum logic [1:0] {
		MODE_COUNT  = 2'd0,
		MODE_SET    = 2'd1,
		MODE_STOP   = 2'd2,
		MODE_REINIT = 2'd3
	} mode_t;

	localparam logic [31:0] FULL_ROUND        = 32'd65536;
	localparam logic [31:0] NEAR_LIMIT        = 32'd75536;
	localparam logic [31:0] PULL_BACK_W       = 32'd10000;
	localparam logic [15:0] PULL_BACK         = 16'd10000;
	localparam logic [15:0] TICK_PERIOD_RESET = 16'd40000;

	typedef struct packed {
		logic [15:0] cmp;
		logic [31:0] rem;
	} place_t;

	typedef struct packed {
		logic step_pulse;
		logic system_tick;
		logic step_armed;
	} result_t;

	// place the step compare for a remaining delay counted from base
	function automatic place_t place_step(input logic [15:0] base, input logic [31:0] rem);
		place_t p;
		p.cmp = base;
		p.rem = rem;
		if (rem < FULL_ROUND) begin
			p.cmp = base + rem[15:0];
		end else if (rem < NEAR_LIMIT) begin
			p.cmp = base - PULL_BACK;
			p.rem = rem + PULL_BACK_W;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- sv/esct_core.sv -----
// Timer state registers and per-word update for both compare channels
`timescale 1ns / 1ps
`default_nettype none

module esct_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [1:0]       mode,
	input  wire logic [30:0]      step_delay,
	input  wire logic [15:0]      tick_period,
	output esct_pkg::result_t     res
);
	import esct_pkg::*;

	logic [15:0] cnt_q, step_cmp_q, tick_cmp_q;
	logic [31:0] rem_q;
	logic        step_en_q, tick_en_q;

	logic [15:0] cnt_n, step_cmp_n, tick_cmp_n, cnt_inc;
	logic [31:0] rem_n, rem_src;
	logic        step_en_n, tick_en_n, pulse, tick, do_place;
	place_t      placed;

	assign cnt_inc = cnt_q + 16'd1;

	always_comb begin
		rem_src = {1'b0, step_delay};
		if (mode_t'(mode) == MODE_COUNT) rem_src = rem_q - FULL_ROUND;
		placed = place_step(step_cmp_q, rem_src);
	end

	always_comb begin
		cnt_n      = cnt_q;
		step_cmp_n = step_cmp_q;
		tick_cmp_n = tick_cmp_q;
		rem_n      = rem_q;
		step_en_n  = step_en_q;
		tick_en_n  = tick_en_q;
		pulse      = 1'b0;
		tick       = 1'b0;
		do_place   = 1'b0;
		case (mode_t'(mode))
			MODE_COUNT: begin
				cnt_n = cnt_inc;
				if (step_en_q && cnt_inc == step_cmp_q) begin
					if (rem_q < FULL_ROUND) begin
						pulse     = 1'b1;
						step_en_n = 1'b0;
					end else begin
						do_place = 1'b1;
					end
				end
				if (tick_en_q && cnt_inc == tick_cmp_q) begin
					tick_cmp_n = tick_cmp_q + tick_period;
					tick       = 1'b1;
				end
			end
			MODE_SET: begin
				do_place  = 1'b1;
				step_en_n = 1'b1;
			end
			MODE_STOP: begin
				step_en_n = 1'b0;
				tick_en_n = 1'b0;
			end
			MODE_REINIT: begin
				tick_cmp_n = tick_period;
				tick_en_n  = 1'b1;
				step_en_n  = 1'b0;
			end
			default: begin
				cnt_n = cnt_q;
			end
		endcase
		if (do_place) begin
			step_cmp_n = placed.cmp;
			rem_n      = placed.rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			step_cmp_q <= '0;
			tick_cmp_q <= TICK_PERIOD_RESET;
			rem_q      <= '0;
			step_en_q  <= 1'b0;
			tick_en_q  <= 1'b1;
		end else if (advance) begin
			cnt_q      <= cnt_n;
			step_cmp_q <= step_cmp_n;
			tick_cmp_q <= tick_cmp_n;
			rem_q      <= rem_n;
			step_en_q  <= step_en_n;
			tick_en_q  <= tick_en_n;
		end
	end

	assign res.step_pulse  = pulse;
	assign res.system_tick = tick;
	assign res.step_armed  = step_en_n;

endmodule

`default_nettype wire

// ----- sv/extended_step_compare_timer.sv -----
// Top level of the extended step compare timer: input stage, result register, config
//
//  channel  | handshake            | data
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | mode, step_delay
//  out      | out_valid/ out_ready | step_pulse, system_tick, step_armed
//  cfg      | cfg_valid/ cfg_ready | tick_period
//
// One word per cycle while out_ready holds; each word passes the input register, then the result register.
// Each word updates the timer state in the cycle it leaves the input register.
// A stalled output holds the result and backs up the input stage; one word can wait in each.
// Reset gives tick_period 40000, counter and step compare zero, channel B armed.
// cfg is always ready and takes effect on the next word.
`timescale 1ns / 1ps
`default_nettype none
`include "extended_step_compare_timer_defines.svh"

module extended_step_compare_timer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [30:0] step_delay,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             step_pulse,
	output logic             system_tick,
	output logic             step_armed,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] tick_period
);
	import esct_pkg::*;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [30:0] delay_s1;
	logic        out_valid_q;
	result_t     res_q, res;
	logic [15:0] period_q;
	logic        out_free, advance;

	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			delay_s1 <= step_delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= TICK_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= tick_period;
		end
	end

	esct_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.mode        (mode_s1),
		.step_delay  (delay_s1),
		.tick_period (period_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign step_pulse  = res_q.step_pulse;
	assign system_tick = res_q.system_tick;
	assign step_armed  = res_q.step_armed;

	`ESCT_ASSERT_NOW(a_pulse_disarms, out_valid_q && res_q.step_pulse, !res_q.step_armed, "step pulse with channel A still armed")
	`ESCT_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready, "input stalled with result register empty")
	`ESCT_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "word left input stage without a result")
	`ESCT_ASSERT_NEXT(a_stop_disarms, advance && (mode_s1 == MODE_STOP || mode_s1 == MODE_REINIT), !res_q.step_armed && !res_q.step_pulse && !res_q.system_tick, "stop or reinitialise left activity")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the extended step compare timer
`timescale 1ns / 1ps

module testbench;
	import esct_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	mode_t       mode;
	logic [30:0] step_delay;
	logic        out_valid;
	logic        out_ready;
	logic        step_pulse;
	logic        system_tick;
	logic        step_armed;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] tick_period;

	extended_step_compare_timer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.step_delay  (step_delay),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.step_pulse  (step_pulse),
		.system_tick (system_tick),
		.step_armed  (step_armed),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.tick_period (tick_period)
	);

	// timer state as predicted
	logic [15:0] cnt;
	logic [15:0] step_cmp;
	logic [15:0] tick_cmp;
	logic [31:0] step_left;
	logic        step_on;
	logic        tick_on;
	logic [15:0] period;

	result_t due_words[$];
	result_t latest_word;
	int      fail_count;
	int      in_gap_pct;
	int      out_gap_pct;
	int      hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [30:0] any_delay();
		return 31'($urandom());
	endfunction

	function automatic void place_step_cmp();
		if (step_left < FULL_ROUND) begin
			step_cmp = step_cmp + step_left[15:0];
		end else if (step_left < NEAR_LIMIT) begin
			step_cmp  = step_cmp - PULL_BACK;
			step_left = step_left + PULL_BACK_W;
		end
	endfunction

	function automatic result_t advance_timer(input mode_t m, input logic [30:0] d);
		result_t r;
		r = '0;
		case (m)
			MODE_COUNT: begin
				cnt = cnt + 16'd1;
				if (step_on && cnt == step_cmp) begin
					if (step_left < FULL_ROUND) begin
						r.step_pulse = 1'b1;
						step_on      = 1'b0;
					end else begin
						step_left = step_left - FULL_ROUND;
						place_step_cmp();
					end
				end
				if (tick_on && cnt == tick_cmp) begin
					tick_cmp      = tick_cmp + period;
					r.system_tick = 1'b1;
				end
			end
			MODE_SET: begin
				step_left = {1'b0, d};
				place_step_cmp();
				step_on = 1'b1;
			end
			MODE_STOP: begin
				step_on = 1'b0;
				tick_on = 1'b0;
			end
			default: begin
				tick_cmp = period;
				tick_on  = 1'b1;
				step_on  = 1'b0;
			end
		endcase
		r.step_armed = step_on;
		return r;
	endfunction

	// valid is left high on return; drain() takes it down, and the next call drives its own word
	task automatic send_word(input mode_t m, input logic [30:0] d);
		if ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		step_delay <= d;
		do @(posedge clk); while (!in_ready);
		latest_word = advance_timer(m, d);
		due_words.push_back(latest_word);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] p);
		drain();
		cfg_valid   <= 1'b1;
		tick_period <= p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		period = p;
		@(posedge clk);
	endtask

	// puts channel B a few ticks ahead of the counter, then runs at next_period
	task automatic align_ticks(input logic [15:0] next_period);
		write_period(cnt + 16'($urandom_range(2, 20)));
		send_word(MODE_REINIT, any_delay());
		write_period(next_period);
	endtask

	// arms channel A lead ticks ahead, places long_delay from there and runs up to the
	// first compare match; then aims a few ticks past the counter and runs to the step
	task automatic run_round_match(input logic [15:0] lead, input logic [31:0] long_delay,
			input int ticks);
		send_word(MODE_SET, {15'd0, cnt - step_cmp + lead});
		send_word(MODE_SET, long_delay[30:0]);
		repeat (ticks) send_word(MODE_COUNT, any_delay());
		send_word(MODE_SET, {15'd0, cnt - step_cmp + 16'($urandom_range(1, 20))});
		while (step_on) send_word(MODE_COUNT, any_delay());
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, actual %0b", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_words.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = due_words.pop_front();
				check_field("step_pulse", want.step_pulse, step_pulse);
				check_field("system_tick", want.system_tick, system_tick);
				check_field("step_armed", want.step_armed, step_armed);
			end
		end
	end

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end else if (stall_left == 0 && $urandom_range(0, 99) < out_gap_pct) begin
				stall_left = pick_gap();
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic test_directed_modes();
		in_gap_pct  = 15;
		out_gap_pct = 15;
		send_word(MODE_COUNT, 31'd0);
		send_word(MODE_SET, 31'd2);
		send_word(MODE_COUNT, 31'h7FFF_FFFF);
		send_word(MODE_SET, 31'd0);
		send_word(MODE_SET, 31'h7FFF_FFFF);
		send_word(MODE_SET, 31'd65535);
		send_word(MODE_SET, 31'd65536);
		send_word(MODE_SET, 31'd75535);
		send_word(MODE_SET, 31'd75536);
		send_word(MODE_COUNT, any_delay());
		send_word(MODE_STOP, any_delay());
		send_word(MODE_COUNT, any_delay());
		send_word(MODE_SET, 31'd3);
		send_word(MODE_REINIT, any_delay());
		send_word(MODE_SET, {15'd0, cnt + 16'd2 - step_cmp});
		repeat (3) send_word(MODE_COUNT, any_delay());
	endtask

	// whole counter rounds, pull-back on placement and on a round match
	task automatic test_extended_delay();
		logic [31:0] d;
		in_gap_pct  = 2;
		out_gap_pct = 2;
		d = 32'($urandom_range(65536, 75535));
		run_round_match(16'd10005, d, 5);
		d = 2 * FULL_ROUND + 32'($urandom_range(0, 9999));
		run_round_match(16'd5, d, 5);
		d = FULL_ROUND + 32'($urandom_range(10000, 65535));
		run_round_match(16'd5, d, 5);
		d = 3 * FULL_ROUND + 32'($urandom_range(10000, 65535));
		run_round_match(16'd5, d, 5);
		drain();
	endtask

	task automatic test_both_channels();
		in_gap_pct  = 15;
		out_gap_pct = 15;
		align_ticks(16'd1);
		send_word(MODE_SET, {15'd0, tick_cmp - step_cmp});
		while (step_on) send_word(MODE_COUNT, any_delay());
		repeat (6) send_word(MODE_COUNT, any_delay());
		align_ticks(16'hFFFF);
		repeat (30) send_word(MODE_COUNT, any_delay());
	endtask

	task automatic test_output_stall();
		align_ticks(16'd3);
		in_gap_pct  = 0;
		out_gap_pct = 0;
		hold_req    = 60;
		send_word(MODE_SET, {15'd0, cnt - step_cmp + 16'd12});
		repeat (40) send_word(MODE_COUNT, any_delay());
		// sender waits for every result before going on
		drain();
		repeat (20) send_word(MODE_COUNT, any_delay());
	endtask

	task automatic test_random_traffic();
		int          r;
		int          k;
		logic [15:0] p;
		logic [30:0] d;
		for (int ph = 0; ph < 12; ph++) begin
			k = $urandom_range(0, 9);
			if (k < 4)
				p = 16'($urandom_range(1, 8));
			else if (k < 7)
				p = 16'($urandom_range(9, 64));
			else if (k == 7)
				p = 16'hFFFF;
			else if (k == 8)
				p = 16'd0;
			else
				p = 16'($urandom());
			in_gap_pct  = 15 * $urandom_range(0, 2);
			out_gap_pct = 15 * $urandom_range(0, 2);
			align_ticks(p);
			repeat (130) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					send_word(MODE_COUNT, any_delay());
				end else if (r < 98) begin
					k = $urandom_range(0, 19);
					if (k < 11)
						d = {15'd0, cnt - step_cmp + 16'($urandom_range(1, 40))};
					else if (k < 14)
						d = 31'($urandom_range(0, 63));
					else if (k < 16)
						d = any_delay();
					else if (k < 18)
						d = 31'($urandom_range(65530, 75540));
					else
						d = 31'(FULL_ROUND * $urandom_range(1, 3));
					send_word(MODE_SET, d);
				end else if (r < 99) begin
					send_word(MODE_STOP, any_delay());
				end else begin
					send_word(MODE_REINIT, any_delay());
				end
			end
		end
	endtask

	initial begin
		cnt         = 16'd0;
		step_cmp    = 16'd0;
		tick_cmp    = TICK_PERIOD_RESET;
		step_left   = 32'd0;
		step_on     = 1'b0;
		tick_on     = 1'b1;
		period      = TICK_PERIOD_RESET;
		fail_count  = 0;
		hold_req    = 0;
		in_gap_pct  = 0;
		out_gap_pct = 0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		mode        <= MODE_COUNT;
		step_delay  <= 31'd0;
		cfg_valid   <= 1'b0;
		tick_period <= TICK_PERIOD_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_modes();
		test_extended_delay();
		test_both_channels();
		test_output_stall();
		test_random_traffic();

		drain();
		repeat (8) @(posedge clk);
		if (due_words.size() != 0) begin
			$error("%0d result words never arrived", due_words.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
